>>> hw/rtl/lr2d_pkg.sv
// Shared constants and types for the 2D line rasterizer.
`default_nettype none

package lr2d_pkg;

  // Default coordinate width and the fixed tile code width.
  localparam int unsigned COORD_BITS_DEF = 6;
  localparam int unsigned CODE_BITS      = 8;

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SETUP = 3'b010,
    ST_RUN   = 3'b100
  } lr2d_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/lr2d_if.sv
// Valid/ready channel interfaces for segments in and points out.
`default_nettype none

interface lr2d_seg_if
  import lr2d_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) ();

  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] x_start;
  logic [COORD_BITS-1:0] y_start;
  logic [COORD_BITS-1:0] x_end;
  logic [COORD_BITS-1:0] y_end;
  logic [CODE_BITS-1:0]  tile_code;

  modport source (
    output valid, x_start, y_start, x_end, y_end, tile_code,
    input  ready
  );

  modport sink (
    input  valid, x_start, y_start, x_end, y_end, tile_code,
    output ready
  );

endinterface

interface lr2d_pt_if
  import lr2d_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) ();

  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;
  logic [CODE_BITS-1:0]  plot_code;
  logic                  is_last;

  modport source (
    output valid, point_x, point_y, plot_code, is_last,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, plot_code, is_last,
    output ready
  );

endinterface

`default_nettype wire

>>> hw/rtl/line_raster_2d_top.sv
// Top level of the 2D Bresenham line rasterizer.
//
// Usage: a segment item (start point, end point, tile code) enters on in_seg.
// The block then emits every grid point of the Bresenham line from start to
// end inclusive on out_pt, one item per point, with is_last set on the end
// point. Major axis is the one with the larger delta, x on a tie.
// Timing: the segment is taken in ST_IDLE, the deltas and the initial error
// are formed in ST_SETUP, then in ST_RUN one point leaves per cycle, while
// out_pt is not stalled, through a shared error adder and coordinate
// stepper. A segment has at most 2^COORD_BITS points; in_seg.ready is high
// only while the sequencer is idle. The first point is loaded into the
// output register in ST_RUN, after the pass through ST_SETUP.
// A stall on out_pt holds the output register and freezes the stepper; no
// point is lost or repeated. A new segment can be accepted while the last
// point of the previous one still waits in the output register.
// Reset (synchronous, active low) returns the sequencer to idle and drops
// out_pt.valid.
`default_nettype none

module line_raster_2d_top
  import lr2d_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire      clk,
  input  wire      rst_n,
  lr2d_seg_if.sink in_seg,
  lr2d_pt_if.source out_pt
);

  localparam int unsigned EW = COORD_BITS + 3;

  lr2d_state_t state_r, state_nxt;

  // Raw segment as taken from the channel.
  logic [COORD_BITS-1:0] x_r, y_r, xe_r, ye_r;
  logic [CODE_BITS-1:0]  code_r;

  // Stepper state in major/minor terms.
  logic                  swap_r, swap_nxt;
  logic [COORD_BITS-1:0] a_r, a_nxt, b_r, b_nxt, ae_r, ae_nxt;
  logic                  a_dec_r, a_dec_nxt, b_dec_r, b_dec_nxt;
  logic signed [EW-1:0]  err_r, err_nxt;
  logic signed [EW-1:0]  dmin2_r, dmin2_nxt, dboth_r, dboth_nxt;

  // Output register.
  logic                  out_valid_r, out_valid_nxt;
  logic [COORD_BITS-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic [CODE_BITS-1:0]  out_code_r, out_code_nxt;
  logic                  out_last_r, out_last_nxt;

  // Setup datapath signals.
  logic signed [COORD_BITS:0] dx, dy;
  logic [COORD_BITS-1:0]      adx, ady, dmaj, dmin;
  logic                       x_major;

  // Step datapath signals.
  logic                  slot_free;
  logic                  at_end;
  logic                  step_b;
  logic signed [EW-1:0]  err_add;

  assign in_seg.ready = (state_r == ST_IDLE);
  assign slot_free    = !out_valid_r || out_pt.ready;
  assign at_end       = (a_r == ae_r);

  // Deltas, their magnitudes and the choice of major axis.
  always_comb begin
    dx  = $signed({1'b0, xe_r}) - $signed({1'b0, x_r});
    dy  = $signed({1'b0, ye_r}) - $signed({1'b0, y_r});
    adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
    ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
    x_major = (adx >= ady);
    dmaj = x_major ? adx : ady;
    dmin = x_major ? ady : adx;
  end

  // The minor axis steps on a positive error, or on zero error when the
  // major direction is positive.
  assign step_b  = (!err_r[EW-1] && (err_r != '0)) || ((err_r == '0) && !a_dec_r);
  assign err_add = step_b ? dboth_r : dmin2_r;

  // Sequencer and shared stepper.
  always_comb begin
    state_nxt     = state_r;
    swap_nxt      = swap_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    ae_nxt        = ae_r;
    a_dec_nxt     = a_dec_r;
    b_dec_nxt     = b_dec_r;
    err_nxt       = err_r;
    dmin2_nxt     = dmin2_r;
    dboth_nxt     = dboth_r;
    out_valid_nxt = out_valid_r && !out_pt.ready;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_code_nxt  = out_code_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_seg.valid) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        swap_nxt  = !x_major;
        a_nxt     = x_major ? x_r : y_r;
        b_nxt     = x_major ? y_r : x_r;
        ae_nxt    = x_major ? xe_r : ye_r;
        a_dec_nxt = x_major ? dx[COORD_BITS] : dy[COORD_BITS];
        b_dec_nxt = x_major ? dy[COORD_BITS] : dx[COORD_BITS];
        dmin2_nxt = $signed({2'b00, dmin, 1'b0});
        dboth_nxt = $signed({2'b00, dmin, 1'b0}) - $signed({2'b00, dmaj, 1'b0});
        err_nxt   = $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = swap_r ? b_r : a_r;
          out_y_nxt     = swap_r ? a_r : b_r;
          out_code_nxt  = code_r;
          out_last_nxt  = at_end;
          if (at_end) begin
            state_nxt = ST_IDLE;
          end else begin
            err_nxt = err_r + err_add;
            a_nxt   = a_dec_r ? a_r - 1'b1 : a_r + 1'b1;
            if (step_b) begin
              b_nxt = b_dec_r ? b_r - 1'b1 : b_r + 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_seg.valid && in_seg.ready) begin
      x_r    <= in_seg.x_start;
      y_r    <= in_seg.y_start;
      xe_r   <= in_seg.x_end;
      ye_r   <= in_seg.y_end;
      code_r <= in_seg.tile_code;
    end
    swap_r     <= swap_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    ae_r       <= ae_nxt;
    a_dec_r    <= a_dec_nxt;
    b_dec_r    <= b_dec_nxt;
    err_r      <= err_nxt;
    dmin2_r    <= dmin2_nxt;
    dboth_r    <= dboth_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_code_r <= out_code_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_pt.valid     = out_valid_r;
  assign out_pt.point_x   = out_x_r;
  assign out_pt.point_y   = out_y_r;
  assign out_pt.plot_code = out_code_r;
  assign out_pt.is_last   = out_last_r;

endmodule

`default_nettype wire

>>> sim/line_raster_2d_checker.sv
// Checker for the line rasterizer: watches both channels and predicts every point.
`timescale 1ns / 100ps

module line_raster_2d_checker
  import lr2d_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  seg_valid,
  input  wire                  seg_ready,
  input  wire [COORD_BITS-1:0] seg_x_start,
  input  wire [COORD_BITS-1:0] seg_y_start,
  input  wire [COORD_BITS-1:0] seg_x_end,
  input  wire [COORD_BITS-1:0] seg_y_end,
  input  wire [CODE_BITS-1:0]  seg_tile_code,
  input  wire                  pt_valid,
  input  wire                  pt_ready,
  input  wire [COORD_BITS-1:0] pt_point_x,
  input  wire [COORD_BITS-1:0] pt_point_y,
  input  wire [CODE_BITS-1:0]  pt_plot_code,
  input  wire                  pt_is_last,
  output int                   err_count,
  output int                   pend_count
);

  // One plotted grid point as the block should emit it.
  typedef struct packed {
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic [CODE_BITS-1:0]  code;
    logic                  last;
  } grid_point_t;

  // Points predicted but not yet seen on the output, oldest first.
  grid_point_t pending_points[$];
  grid_point_t want;

  // Print one line per mismatch and count them all.
  task automatic flag_mismatch(input string what, input int got, input int exp_val);
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, exp_val);
    err_count++;
  endtask

  function automatic void add_point(input int x, input int y,
                                    input logic [CODE_BITS-1:0] code, input bit last);
    grid_point_t p;
    p.px   = x[COORD_BITS-1:0];
    p.py   = y[COORD_BITS-1:0];
    p.code = code;
    p.last = last;
    pending_points.push_back(p);
  endfunction

  // Bresenham walk from start to end inclusive. The major axis is the one with
  // the larger delta (x on a tie); on a zero error term the minor axis steps
  // only when the major direction is positive.
  function automatic void rasterize_segment(input int xs, input int ys, input int xe,
                                            input int ye, input logic [CODE_BITS-1:0] code);
    int x, y, dx, dy, sx, sy, ax, ay, err;
    x  = xs;
    y  = ys;
    dx = xe - xs;
    dy = ye - ys;
    sx = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
    sy = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    add_point(x, y, code, (x == xe) && (y == ye));
    if (ax >= ay) begin
      err = 2 * ay - ax;
      while (x != xe) begin
        if (err > 0 || (err == 0 && sx > 0)) begin
          err -= 2 * ax;
          y += sy;
        end
        err += 2 * ay;
        x += sx;
        add_point(x, y, code, x == xe);
      end
    end else begin
      err = 2 * ax - ay;
      while (y != ye) begin
        if (err > 0 || (err == 0 && sy > 0)) begin
          err -= 2 * ay;
          x += sx;
        end
        err += 2 * ax;
        y += sy;
        add_point(x, y, code, y == ye);
      end
    end
  endfunction

  // Check outgoing points first: a point leaving at this edge can only belong
  // to a segment taken at an earlier edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      err_count = 0;
    end else begin
      if (pt_valid && pt_ready) begin
        if (pending_points.size() == 0) begin
          flag_mismatch("point with nothing pending (x)", pt_point_x, -1);
        end else begin
          want = pending_points.pop_front();
          if (pt_point_x !== want.px) flag_mismatch("point_x", pt_point_x, want.px);
          if (pt_point_y !== want.py) flag_mismatch("point_y", pt_point_y, want.py);
          if (pt_plot_code !== want.code) flag_mismatch("plot_code", pt_plot_code, want.code);
          if (pt_is_last !== want.last) flag_mismatch("is_last", pt_is_last, want.last);
        end
      end
      if (seg_valid && seg_ready) begin
        rasterize_segment(seg_x_start, seg_y_start, seg_x_end, seg_y_end, seg_tile_code);
      end
    end
    pend_count = pending_points.size();
  end

endmodule

>>> sim/line_raster_2d_top_tb.sv
// Testbench top for the line rasterizer: clock, reset, segment stimulus and verdict.
`timescale 1ns / 100ps

module line_raster_2d_top_tb;
  import lr2d_pkg::*;

  localparam int unsigned CB   = COORD_BITS_DEF;
  localparam int          MAXC = (1 << CB) - 1;

  // One segment as offered on the input channel.
  typedef struct packed {
    logic [CB-1:0]        xs;
    logic [CB-1:0]        ys;
    logic [CB-1:0]        xe;
    logic [CB-1:0]        ye;
    logic [CODE_BITS-1:0] code;
  } segment_t;

  logic clk;
  logic rst_n;
  int   err_count;
  int   pend_count;
  int   src_gap_pct;
  int   sink_stall_pct;
  int   hold_len;
  int   hold_seq;

  lr2d_seg_if #(.COORD_BITS(CB)) seg_if ();
  lr2d_pt_if  #(.COORD_BITS(CB)) pt_if ();

  line_raster_2d_top #(.COORD_BITS(CB)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_seg (seg_if.sink),
    .out_pt (pt_if.source)
  );

  line_raster_2d_checker #(.COORD_BITS(CB)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .seg_valid     (seg_if.valid),
    .seg_ready     (seg_if.ready),
    .seg_x_start   (seg_if.x_start),
    .seg_y_start   (seg_if.y_start),
    .seg_x_end     (seg_if.x_end),
    .seg_y_end     (seg_if.y_end),
    .seg_tile_code (seg_if.tile_code),
    .pt_valid      (pt_if.valid),
    .pt_ready      (pt_if.ready),
    .pt_point_x    (pt_if.point_x),
    .pt_point_y    (pt_if.point_y),
    .pt_plot_code  (pt_if.plot_code),
    .pt_is_last    (pt_if.is_last),
    .err_count     (err_count),
    .pend_count    (pend_count)
  );

  // Free-running 100 MHz clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Overall time limit.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Output side: random stalls, plus a long hold-off whenever one is requested.
  initial begin : sink_side
    int seen_seq;
    int hold_left;
    seen_seq  = 0;
    hold_left = 0;
    pt_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seq != seen_seq) begin
        seen_seq  = hold_seq;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        pt_if.ready <= 1'b0;
      end else begin
        pt_if.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  function automatic segment_t make_segment(input int xs, input int ys, input int xe,
                                            input int ye, input int code);
    segment_t s;
    s.xs   = xs[CB-1:0];
    s.ys   = ys[CB-1:0];
    s.xe   = xe[CB-1:0];
    s.ye   = ye[CB-1:0];
    s.code = code[CODE_BITS-1:0];
    return s;
  endfunction

  function automatic int clamp_coord(input int v);
    return (v < 0) ? 0 : ((v > MAXC) ? MAXC : v);
  endfunction

  // Mix of fully random segments, short ones, straight or diagonal ones and
  // single points, so that both the long and the short paths get exercised.
  function automatic segment_t random_segment();
    int kind, xs, ys, xe, ye, span, dir;
    kind = $urandom_range(9);
    xs   = $urandom_range(MAXC);
    ys   = $urandom_range(MAXC);
    xe   = $urandom_range(MAXC);
    ye   = $urandom_range(MAXC);
    if (kind >= 4 && kind < 8) begin
      xe = clamp_coord(xs + $urandom_range(8) - 4);
      ye = clamp_coord(ys + $urandom_range(8) - 4);
    end else if (kind == 8) begin
      dir = $urandom_range(2);
      if (dir == 0) begin
        ye = ys;
      end else if (dir == 1) begin
        xe = xs;
      end else begin
        span = (xe > xs) ? xe - xs : xs - xe;
        ys   = $urandom_range(MAXC - span);
        ye   = ys + span;
        if ($urandom_range(1)) begin
          ye = ys;
          ys = ys + span;
        end
      end
    end else if (kind == 9) begin
      xe = xs;
      ye = ys;
    end
    return make_segment(xs, ys, xe, ye, $urandom_range(255));
  endfunction

  // Offer one segment after a random gap and hold it until it is taken.
  // Returns at the falling edge after acceptance.
  task automatic offer_segment(input segment_t s);
    while ($urandom_range(99) < src_gap_pct) begin
      seg_if.valid <= 1'b0;
      @(negedge clk);
    end
    seg_if.valid     <= 1'b1;
    seg_if.x_start   <= s.xs;
    seg_if.y_start   <= s.ys;
    seg_if.x_end     <= s.xe;
    seg_if.y_end     <= s.ye;
    seg_if.tile_code <= s.code;
    @(posedge clk);
    while (!seg_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering and wait until every predicted point has come out.
  task automatic drain_points();
    seg_if.valid <= 1'b0;
    @(negedge clk);
    while (pend_count != 0) @(negedge clk);
  endtask

  // Main stimulus: directed segments, a back-pressure burst, then random
  // segments under four idling mixes.
  initial begin
    rst_n            = 1'b0;
    seg_if.valid     = 1'b0;
    seg_if.x_start   = '0;
    seg_if.y_start   = '0;
    seg_if.x_end     = '0;
    seg_if.y_end     = '0;
    seg_if.tile_code = '0;
    src_gap_pct      = 0;
    sink_stall_pct   = 0;
    hold_len         = 0;
    hold_seq         = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Single points, straight runs both ways, diagonals, ties and zero-error steps.
    offer_segment(make_segment(0, 0, 0, 0, 8'h00));
    offer_segment(make_segment(MAXC, MAXC, MAXC, MAXC, 8'hFF));
    offer_segment(make_segment(0, 17, MAXC, 17, 8'hAA));
    offer_segment(make_segment(MAXC, 40, 0, 40, 8'h55));
    offer_segment(make_segment(5, 0, 5, MAXC, 8'h01));
    offer_segment(make_segment(50, MAXC, 50, 0, 8'h80));
    offer_segment(make_segment(0, 0, MAXC, MAXC, 8'h0F));
    offer_segment(make_segment(MAXC, MAXC, 0, 0, 8'hF0));
    offer_segment(make_segment(MAXC, 0, 0, MAXC, 8'h3C));
    offer_segment(make_segment(0, MAXC, MAXC, 0, 8'hC3));
    offer_segment(make_segment(0, 0, 4, 2, 8'h11));
    offer_segment(make_segment(4, 2, 0, 0, 8'h22));
    offer_segment(make_segment(0, 0, 2, 4, 8'h33));
    offer_segment(make_segment(2, 4, 0, 0, 8'h44));
    offer_segment(make_segment(10, 10, 7, 13, 8'h66));
    offer_segment(make_segment(0, 0, MAXC, MAXC - 1, 8'h77));
    offer_segment(make_segment(0, 0, MAXC - 1, MAXC, 8'h99));
    offer_segment(make_segment(MAXC, 0, 0, 1, 8'hBB));
    offer_segment(make_segment(0, MAXC, 1, 0, 8'hCC));
    offer_segment(make_segment(30, 30, 31, 32, 8'hDD));
    drain_points();

    // Output held off for a long stretch while segments keep coming.
    hold_len = 400;
    hold_seq++;
    repeat (12) offer_segment(random_segment());
    drain_points();

    // Random segments under each idling mix.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          src_gap_pct    = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_gap_pct    = 71;
          sink_stall_pct = 0;
        end
        2: begin
          src_gap_pct    = 0;
          sink_stall_pct = 71;
        end
        default: begin
          src_gap_pct    = 14;
          sink_stall_pct = 14;
        end
      endcase
      repeat (82) offer_segment(random_segment());
      drain_points();
    end

    // Let any stray points show up before the verdict.
    repeat (100) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/lr2d_pkg.sv
hw/rtl/lr2d_if.sv
hw/rtl/line_raster_2d_top.sv
sim/line_raster_2d_checker.sv
sim/line_raster_2d_top_tb.sv
